// ===== design/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared sizes, constants and the digit-to-character mapping for the
// integer to ASCII radix unit.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int MAX_DIGITS  = 32;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int INDEX_W     = $clog2(MAX_DIGITS);
   localparam int BIT_W       = $clog2(VALUE_WIDTH);

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);

   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LETTER = 8'h37;

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] digit);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(digit);
      if (digit < RADIX_DEC) begin
         return wide + CHAR_ZERO;
      end
      return wide + CHAR_LETTER;
   endfunction

endpackage

// ===== design/integer_to_ascii_radix_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit
// Converts a signed integer to ASCII text in a programmable radix, 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   Write the radix on csr_write_data with csr_write_enable high, only while
//   busy is low; values outside 2..36 are saturated. Reset sets radix ten.
//   A transaction is taken on req_value when start is high and busy is low.
//   Characters leave most significant first, one per cycle, each marked by
//   rsp_strobe for exactly one cycle; rsp_last marks the final character.
//   A leading '-' appears only for a negative value in radix ten; all other
//   radixes treat the value as unsigned.
// Timing:
//   Each digit comes from a restoring division, one quotient bit per cycle,
//   and digits are found least significant first until the quotient is zero
//   or 32 digits are held. Characters are sent once all digits are held;
//   busy is already low in the cycle that holds the last strobe.
//   The worst case is radix two with 32 digits.
// Reset:
//   Synchronous, active high; drops any transaction in flight.
//   The receiver cannot stall; characters are delivered unconditionally.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                 rsp_strobe,
   output logic [itoa_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                 rsp_last,
   input  logic                                 csr_write_enable,
   input  logic [itoa_pkg::RADIX_W-1:0]         csr_write_data
);
   import itoa_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_type;

   state_type                state_ff;
   logic [RADIX_W-1:0]       radix_ff;
   logic [RADIX_W-1:0]       radix_in;
   logic [VALUE_WIDTH-1:0]   quot_ff;
   logic [VALUE_WIDTH-1:0]   quot_in;
   logic [RADIX_W-1:0]       rem_ff;
   logic [RADIX_W-1:0]       rem_in;
   logic [BIT_W-1:0]         bit_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic [COUNT_W-1:0]       count_in;
   logic                     neg_ff;
   logic                     rsp_strobe_ff;
   logic [CHAR_W-1:0]        rsp_character_ff;
   logic                     rsp_last_ff;
   logic [RADIX_W-1:0]       store_ff [MAX_DIGITS];
   logic [RADIX_W:0]         trial;
   logic                     qbit;
   logic                     accept;
   logic                     neg_in;
   logic [INDEX_W-1:0]       rd_index;
   logic                     last_digit;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      priority if (csr_write_data < RADIX_MIN) begin
         radix_in = RADIX_MIN;
      end else if (csr_write_data > RADIX_MAX) begin
         radix_in = RADIX_MAX;
      end else begin
         radix_in = csr_write_data;
      end
   end

   // one restoring division step
   always_comb begin
      trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
      qbit  = (trial >= {1'b0, radix_ff});
      rem_in = qbit ? RADIX_W'(trial - {1'b0, radix_ff}) : RADIX_W'(trial);
      quot_in = {quot_ff[VALUE_WIDTH-2:0], qbit};
      count_in = count_ff + COUNT_W'(1);
   end

   assign neg_in     = (radix_ff == RADIX_DEC) && req_value[VALUE_WIDTH-1];
   assign rd_index   = INDEX_W'(count_ff - COUNT_W'(1));
   assign last_digit = (count_ff == COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && bit_ff == BIT_W'(VALUE_WIDTH - 1)) begin
         store_ff[INDEX_W'(count_ff)] <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radix_ff      <= RADIX_RESET;
         quot_ff       <= '0;
         rem_ff        <= '0;
         count_ff      <= '0;
         neg_ff        <= 1'b0;
         bit_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_EMIT);
         if (csr_write_enable) begin
            radix_ff <= radix_in;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  neg_ff   <= neg_in;
                  quot_ff  <= neg_in ? VALUE_WIDTH'(-req_value) : VALUE_WIDTH'(req_value);
                  rem_ff   <= '0;
                  bit_ff   <= '0;
                  count_ff <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               quot_ff <= quot_in;
               if (bit_ff == BIT_W'(VALUE_WIDTH - 1)) begin
                  count_ff <= count_in;
                  rem_ff   <= '0;
                  bit_ff   <= '0;
                  if (quot_in == '0 || count_in == COUNT_W'(MAX_DIGITS)) begin
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  rem_ff <= rem_in;
                  bit_ff <= bit_ff + BIT_W'(1);
               end
            end
            ST_EMIT: begin
               if (neg_ff) begin
                  rsp_character_ff <= CHAR_MINUS;
                  rsp_last_ff      <= 1'b0;
                  neg_ff           <= 1'b0;
               end else begin
                  rsp_character_ff <= digit_glyph(store_ff[rd_index]);
                  rsp_last_ff      <= last_digit;
                  count_ff         <= count_ff - COUNT_W'(1);
                  if (last_digit) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EMIT))
      else $error("character strobe without emit phase");

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIV)
      else $error("accepted transaction did not start division");

   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      radix_ff >= RADIX_MIN && radix_ff <= RADIX_MAX)
      else $error("radix out of range");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < radix_ff)
      else $error("partial remainder not below radix");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> count_ff != '0)
      else $error("emit phase with no digits held");
`endif

endmodule

// ===== sim/tb_integer_to_ascii_radix_unit.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_unit
// Self-checking bench for the integer to ASCII radix unit. A queue-fed
// driver issues conversion transactions with random pauses, and a shadow
// predictor turns each accepted value into the characters it should produce.
// A monitor compares every strobed character and last flag in order. The
// radix register is rewritten between drained phases: reset value, clamped
// extremes, then a list of fixed and random settings.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_unit;
   import itoa_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASE_ITEMS = 30;
   localparam logic [8*36-1:0] DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_strobe;
   logic [CHAR_W-1:0]             rsp_character;
   logic                          rsp_last;
   logic                          csr_write_enable = 1'b0;
   logic [RADIX_W-1:0]            csr_write_data = '0;

   logic [VALUE_WIDTH-1:0] value_queue[$];
   char_type               char_queue[$];
   logic [RADIX_W-1:0]     radix_shadow = RADIX_RESET;
   int                     gap_left = 0;
   bit                     burst = 1'b0;
   int                     fail_count = 0;
   int                     cycle_count = 0;

   integer_to_ascii_radix_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic predict_text(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [RADIX_W-1:0]     digits[MAX_DIGITS];
      int                     n;
      bit                     neg;
      char_type               c;
      neg = (radix_shadow == RADIX_DEC) && value[VALUE_WIDTH-1];
      mag = neg ? (VALUE_WIDTH'(0) - value) : value;
      n = 0;
      do begin
         digits[n] = RADIX_W'(mag % radix_shadow);
         mag = mag / radix_shadow;
         n++;
      end while (mag != 0 && n < MAX_DIGITS);
      if (neg) begin
         c.code = CHAR_MINUS;
         c.last = 1'b0;
         char_queue.push_back(c);
      end
      for (int k = n - 1; k >= 0; k--) begin
         c.code = DIGIT_SET[8*(35 - int'(digits[k])) +: 8];
         c.last = (k == 0);
         char_queue.push_back(c);
      end
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 6))
         0: v = $urandom_range(0, 100);
         1: v = VALUE_WIDTH'(0) - VALUE_WIDTH'($urandom_range(1, 100));
         2: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
         3: v = 32'h8000_0000 + $urandom_range(0, 3);
         4: v = $urandom >> $urandom_range(0, 31);
         5: begin
            v = 1;
            repeat ($urandom_range(1, 31)) v = v * radix_shadow;
            v = v + $urandom_range(0, 2) - 1;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // drive transactions from the queue
   always @(posedge clock) begin : driver
      int pause;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         predict_text(req_value);
         if ($urandom_range(0, 19) == 0) burst = !burst;
         pause = burst ? 0 : $urandom_range(0, 8);
         if (pause == 0 && value_queue.size() != 0) begin
            req_value <= value_queue.pop_front();
         end else begin
            start <= 1'b0;
            gap_left <= pause;
         end
      end else if (!start) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (value_queue.size() != 0) begin
            start <= 1'b1;
            req_value <= value_queue.pop_front();
         end
      end
   end

   // check every strobed character against the oldest prediction
   always @(posedge clock) begin : monitor
      char_type want;
      if (!reset && rsp_strobe) begin
         if (char_queue.size() == 0) begin
            $error("character: expected none, actual %h", rsp_character);
            fail_count++;
         end else begin
            want = char_queue.pop_front();
            if (rsp_character !== want.code) begin
               $error("character: expected %h, actual %h", want.code, rsp_character);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("integer_to_ascii_radix_unit regression: fail");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (value_queue.size() != 0 || start || busy || char_queue.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] setting);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (setting < RADIX_MIN) radix_shadow = RADIX_MIN;
      else if (setting > RADIX_MAX) radix_shadow = RADIX_MAX;
      else radix_shadow = setting;
   endtask

   initial begin : stimulus
      logic [RADIX_W-1:0] settings[12];
      settings = '{6'd37, 6'd16, 6'd8, 6'd1, 6'd10, 6'd3,
                   6'd2, 6'd36, 6'd7, 6'd10, 6'd0, 6'd0};
      settings[10] = RADIX_W'($urandom_range(0, 63));
      settings[11] = RADIX_W'($urandom_range(0, 63));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset radix: zero, signs, decade edges, extremes
      value_queue.push_back(32'd0);
      value_queue.push_back(32'd1);
      value_queue.push_back(32'hFFFF_FFFF);
      value_queue.push_back(32'd9);
      value_queue.push_back(32'd10);
      value_queue.push_back(32'h7FFF_FFFF);
      value_queue.push_back(32'h8000_0000);
      value_queue.push_back(-32'sd10);
      value_queue.push_back(32'd123456789);
      value_queue.push_back(-32'sd987654321);
      wait_idle();

      // clamp low to radix two, longest text
      write_radix(6'd0);
      value_queue.push_back(32'd0);
      value_queue.push_back(32'hFFFF_FFFF);
      value_queue.push_back(32'h8000_0000);
      value_queue.push_back(32'd1);
      value_queue.push_back(32'h5555_5555);
      wait_idle();

      // clamp high to radix 36, top digits
      write_radix(6'd63);
      value_queue.push_back(32'd0);
      value_queue.push_back(32'd35);
      value_queue.push_back(32'd36);
      value_queue.push_back(32'hFFFF_FFFF);
      value_queue.push_back(32'h7FFF_FFFF);
      wait_idle();

      foreach (settings[p]) begin
         write_radix(settings[p]);
         repeat (PHASE_ITEMS) value_queue.push_back(random_value());
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && char_queue.size() == 0) begin
         $display("integer_to_ascii_radix_unit regression: pass");
      end else begin
         $display("integer_to_ascii_radix_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== integer_to_ascii_radix_unit.f =====
design/itoa_pkg.sv
design/integer_to_ascii_radix_unit.sv
sim/tb_integer_to_ascii_radix_unit.sv
